### rtl/bwt_forward_transform_defines.svh
// Assertion macros for the forward block-sort transform.
`ifndef BWT_FORWARD_TRANSFORM_DEFINES_SVH
`define BWT_FORWARD_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
`define BWT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bwt assertion failed");
`define BWT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bwt sequencing assertion failed");
`else
`define BWT_ASSERT(label, prop)
`define BWT_ASSERT_NEXT(label, pre, post)
`endif
`endif

### rtl/bwt_pkg.sv
// Shared constants for the forward block-sort transform.
`timescale 1ns / 1ps
package bwt_pkg;
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;
  localparam int   ByteW     = 8;
  localparam int   RowW      = 10;
endpackage

### rtl/bwt_ram.sv
// Generic memory: one write port, two read ports with registered data.
`timescale 1ns / 1ps
module bwt_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [DW-1:0] rdata0_o,
  output logic [DW-1:0] rdata1_o
);
  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end
endmodule

### rtl/bwt_sorter.sv
// Bottom-up merge sort of rotation starts with a byte-serial rotation compare.
`timescale 1ns / 1ps
module bwt_sorter #(
  parameter int N  = 1024,
  parameter int AW = 10,
  parameter int LW = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [LW-1:0]           len_i,
  output logic                    done_o,
  output logic [AW-1:0]           primary_o,
  output logic [AW-1:0]           blk_raddr0_o,
  output logic [AW-1:0]           blk_raddr1_o,
  input  logic [bwt_pkg::ByteW-1:0] blk_rdata0_i,
  input  logic [bwt_pkg::ByteW-1:0] blk_rdata1_i,
  input  logic [AW-1:0]           fetch_addr_i,
  output logic [AW-1:0]           fetch_data_o
);
  localparam int CW = LW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_RUN, S_MERGE, S_RDIDX, S_CMPRD, S_CMP
  } state_e;

  state_e        state_q;
  logic          sel_q;
  logic [LW-1:0] n_q, k_q;
  logic [CW-1:0] w_q, lo_q, mid_q, hi_q, p_q, q_q, o_q;
  logic [AW-1:0] a_q, b_q, va_q, vb_q, prim_q;

  logic          we, we0, we1, take_p, take_q;
  logic [AW-1:0] wdata, src0, src1, raddr0;
  logic [AW-1:0] r00, r01, r10, r11;
  logic [CW-1:0] n_ext, w2, mid_c, hi_c;
  logic [LW-1:0] a_inc, b_inc;

  assign n_ext = CW'(n_q);
  assign w2    = w_q << 1;
  assign mid_c = (lo_q + w_q < n_ext) ? lo_q + w_q : n_ext;
  assign hi_c  = (mid_c + w_q < n_ext) ? mid_c + w_q : n_ext;
  assign a_inc = LW'(a_q) + LW'(1);
  assign b_inc = LW'(b_q) + LW'(1);

  // sel_q names the array holding the current sorted runs; writes go to the other
  assign src0 = sel_q ? r10 : r00;
  assign src1 = sel_q ? r11 : r01;
  assign raddr0 = (state_q == S_IDLE) ? fetch_addr_i : p_q[AW-1:0];
  assign fetch_data_o = src0;
  assign we0 = we & sel_q;
  assign we1 = we & ~sel_q;
  assign blk_raddr0_o = a_q;
  assign blk_raddr1_o = b_q;
  assign primary_o = prim_q;

  always_comb begin
    we = 1'b0;
    wdata = va_q;
    take_p = 1'b0;
    take_q = 1'b0;
    unique case (state_q)
      S_INIT: begin
        we = 1'b1;
        wdata = o_q[AW-1:0];
      end
      S_RDIDX: begin
        if (q_q >= hi_q) begin
          we = 1'b1; wdata = src0; take_p = 1'b1;
        end else if (p_q >= mid_q) begin
          we = 1'b1; wdata = src1; take_q = 1'b1;
        end
      end
      S_CMP: begin
        if (blk_rdata0_i < blk_rdata1_i) begin
          we = 1'b1; wdata = va_q; take_p = 1'b1;
        end else if (blk_rdata0_i > blk_rdata1_i) begin
          we = 1'b1; wdata = vb_q; take_q = 1'b1;
        end else if (k_q + LW'(1) == n_q) begin
          // equal rotations keep ascending start order
          we = 1'b1; wdata = va_q; take_p = 1'b1;
        end
      end
      default: ;
    endcase
  end

  bwt_ram #(.DW(AW), .DEPTH(N), .AW(AW)) u_idx0 (
    .clk_i, .we_i(we0), .waddr_i(o_q[AW-1:0]), .wdata_i(wdata),
    .raddr0_i(raddr0), .raddr1_i(q_q[AW-1:0]), .rdata0_o(r00), .rdata1_o(r01)
  );
  bwt_ram #(.DW(AW), .DEPTH(N), .AW(AW)) u_idx1 (
    .clk_i, .we_i(we1), .waddr_i(o_q[AW-1:0]), .wdata_i(wdata),
    .raddr0_i(raddr0), .raddr1_i(q_q[AW-1:0]), .rdata0_o(r10), .rdata1_o(r11)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
      done_o  <= 1'b0;
      prim_q  <= '0;
      n_q <= '0; k_q <= '0;
      w_q <= '0; lo_q <= '0; mid_q <= '0; hi_q <= '0;
      p_q <= '0; q_q <= '0; o_q <= '0;
      a_q <= '0; b_q <= '0; va_q <= '0; vb_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (we && wdata == '0) begin
        prim_q <= o_q[AW-1:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            n_q <= len_i;
            o_q <= '0;
            sel_q <= 1'b1;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          o_q <= o_q + CW'(1);
          if (o_q + CW'(1) == n_ext) begin
            sel_q <= 1'b0;
            w_q <= CW'(1);
            lo_q <= '0;
            if (n_q == LW'(1)) begin
              done_o <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (lo_q >= n_ext) begin
            sel_q <= ~sel_q;
            w_q <= w2;
            lo_q <= '0;
            if (w2 >= n_ext) begin
              done_o <= 1'b1;
              state_q <= S_IDLE;
            end
          end else begin
            mid_q <= mid_c;
            hi_q <= hi_c;
            p_q <= lo_q;
            q_q <= mid_c;
            o_q <= lo_q;
            state_q <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (p_q >= mid_q && q_q >= hi_q) begin
            lo_q <= lo_q + w2;
            state_q <= S_RUN;
          end else begin
            state_q <= S_RDIDX;
          end
        end
        S_RDIDX: begin
          va_q <= src0;
          vb_q <= src1;
          a_q <= src0;
          b_q <= src1;
          k_q <= '0;
          if (take_p || take_q) begin
            state_q <= S_MERGE;
          end else begin
            state_q <= S_CMPRD;
          end
        end
        S_CMPRD: state_q <= S_CMP;
        S_CMP: begin
          if (take_p || take_q) begin
            state_q <= S_MERGE;
          end else begin
            a_q <= (a_inc == n_q) ? '0 : a_inc[AW-1:0];
            b_q <= (b_inc == n_q) ? '0 : b_inc[AW-1:0];
            k_q <= k_q + LW'(1);
            state_q <= S_CMPRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (take_p || take_q) begin
        o_q <= o_q + CW'(1);
      end
      if (take_p) begin
        p_q <= p_q + CW'(1);
      end
      if (take_q) begin
        q_q <= q_q + CW'(1);
      end
    end
  end
endmodule

### rtl/bwt_forward_transform.sv
// Top level of the forward block-sort transform: load, sort and fetch control.
`timescale 1ns / 1ps
`include "bwt_forward_transform_defines.svh"
// Load beats (tuser = 0) write one byte each, one per cycle; tlast or a full
// store closes the block. A single sequencer then merge-sorts all rotations,
// comparing one byte pair per pass through a read state and a compare state;
// the sort stalls the input, after a setup pass that writes each start index.
// Fetch beats (tuser = 1) each return one output byte through an index read,
// a byte read and the output register; no new fetch is taken until the
// previous result is registered. A fetch whose result finds the previous beat
// still held at the output waits in the last stage, with the input not ready,
// until that beat is taken. Loads during output and fetches during loading
// are consumed without a result. No clearing pass is needed after reset.
module bwt_forward_transform #(
  parameter int BLOCK_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] cmd
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] out_byte, [17:8] row, [27:18] primary_row
  output logic        m_axis_tlast_o
);
  localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int LW = $clog2(BLOCK_BYTES + 1);

  typedef enum logic [2:0] {S_LOAD, S_SORT, S_EMIT, S_F1, S_F2} state_e;

  state_e        state_q;
  logic [LW-1:0] len_q, ptr_q;
  logic          out_valid_q, out_last_q;
  logic [7:0]    out_byte_q;
  logic [bwt_pkg::RowW-1:0] out_row_q, out_prim_q;

  logic          in_acc, load_acc, fetch_acc, sort_start, sort_done;
  logic [LW-1:0] len_inc, ptr_inc;
  logic [AW-1:0] primary, sa0, sa1, prev, start_idx, blk_raddr1;
  logic [7:0]    bd0, bd1;
  logic [31:0]   ptr_wide, prim_wide;

  assign s_axis_tready_o = (state_q == S_LOAD || state_q == S_EMIT);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_acc  = in_acc && state_q == S_LOAD && s_axis_tuser_i == bwt_pkg::CMD_LOAD;
  assign fetch_acc = in_acc && state_q == S_EMIT && s_axis_tuser_i == bwt_pkg::CMD_FETCH;
  assign len_inc   = len_q + LW'(1);
  assign ptr_inc   = ptr_q + LW'(1);
  assign sort_start = load_acc && (s_axis_tlast_i || len_inc == LW'(BLOCK_BYTES));

  assign prev = (start_idx == '0) ? AW'(len_q - LW'(1)) : start_idx - AW'(1);
  // keep the byte read on the same address while a result waits in S_F2
  assign blk_raddr1 = (state_q == S_F1 || state_q == S_F2) ? prev : sa1;
  assign ptr_wide  = 32'(ptr_q);
  assign prim_wide = 32'(primary);

  bwt_ram #(.DW(8), .DEPTH(BLOCK_BYTES), .AW(AW)) u_block (
    .clk_i, .we_i(load_acc), .waddr_i(len_q[AW-1:0]), .wdata_i(s_axis_tdata_i),
    .raddr0_i(sa0), .raddr1_i(blk_raddr1), .rdata0_o(bd0), .rdata1_o(bd1)
  );

  bwt_sorter #(.N(BLOCK_BYTES), .AW(AW), .LW(LW)) u_sorter (
    .clk_i, .rst_ni, .start_i(sort_start), .len_i(len_inc), .done_o(sort_done),
    .primary_o(primary), .blk_raddr0_o(sa0), .blk_raddr1_o(sa1),
    .blk_rdata0_i(bd0), .blk_rdata1_i(bd1),
    .fetch_addr_i(ptr_q[AW-1:0]), .fetch_data_o(start_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      len_q <= '0;
      ptr_q <= '0;
      out_valid_q <= 1'b0;
      out_last_q <= 1'b0;
      out_byte_q <= '0;
      out_row_q <= '0;
      out_prim_q <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (load_acc) begin
            len_q <= len_inc;
            if (sort_start) begin
              state_q <= S_SORT;
            end
          end
        end
        S_SORT: begin
          if (sort_done) begin
            ptr_q <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (fetch_acc) begin
            state_q <= S_F1;
          end
        end
        S_F1: state_q <= S_F2;
        S_F2: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_byte_q <= bd1;
            out_row_q <= ptr_wide[bwt_pkg::RowW-1:0];
            out_prim_q <= prim_wide[bwt_pkg::RowW-1:0];
            out_last_q <= (ptr_inc == len_q);
            if (ptr_inc == len_q) begin
              len_q <= '0;
              ptr_q <= '0;
              state_q <= S_LOAD;
            end else begin
              ptr_q <= ptr_inc;
              state_q <= S_EMIT;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'b0, out_prim_q, out_row_q, out_byte_q};

  `BWT_ASSERT_NEXT(a_hold_pending, out_valid_q && !m_axis_tready_i, out_valid_q && $stable(m_axis_tdata_o))
  `BWT_ASSERT_NEXT(a_start_sorts, sort_start, state_q == S_SORT)
  `BWT_ASSERT_NEXT(a_fetch_reads, fetch_acc, state_q == S_F1)
  `BWT_ASSERT(a_result_from_read, $rose(out_valid_q) |-> $past(state_q) == S_F2)
endmodule
